[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define DIVU_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("divider assertion failed");

// Implication across a fixed number of cycles.
`define DIVU_ASSERT_DELAY(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
    else $error("divider latency assertion failed");

`endif

[design/divu_pkg.sv]
package divu_pkg;

  localparam int DIVIDEND_W      = 64;
  localparam int DIVISOR_W       = 16;
  // Quotient bits resolved per pipeline stage by default.
  localparam int STAGE_BITS_DEF  = 4;

  typedef struct packed {
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } in_word_t;

  typedef struct packed {
    logic [DIVIDEND_W-1:0] quotient;
    logic                  divide_by_zero;
  } out_word_t;

  // Working word of one pipeline stage. The upper part of work holds the
  // dividend bits still to be consumed, the lower part the quotient bits
  // produced so far.
  typedef struct packed {
    logic [DIVISOR_W-1:0]  rem;
    logic [DIVIDEND_W-1:0] work;
    logic [DIVISOR_W-1:0]  divisor;
  } stage_t;

endpackage

[design/divide_u64_by_u16_unit.sv]
// Pipelined unsigned divider: a 64-bit dividend by a 16-bit divisor, giving
// the truncated 64-bit quotient. A word is taken at every rising edge where
// start is high; busy never rises, so a new word may be issued every cycle.
// Each word produces exactly one result, shown on out_data for one cycle
// with out_valid high once the word has passed through the STAGES stage
// registers and then the output register (STAGE_BITS defaults to four).
// The receiver cannot hold a result off, and the pipeline never stalls. The
// pipeline is a chain of restoring-division stages: each stage resolves
// STAGE_BITS quotient bits, most significant first, with one 17-bit compare
// and subtract per bit, and that short chain sets the clock period. A zero
// divisor gives quotient 0 with divide_by_zero set. The final remainder is
// not returned. STAGE_BITS must divide 64; values from 1 to 8 are supported.
`include "assert_macros.svh"

module divide_u64_by_u16_unit #(
  parameter int STAGE_BITS = divu_pkg::STAGE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  divu_pkg::in_word_t  in_data,
  output logic               out_valid,
  output divu_pkg::out_word_t out_data
);

  localparam int STAGES = divu_pkg::DIVIDEND_W / STAGE_BITS;
  localparam int LAT    = STAGES + 1;

  // One quotient bit of restoring division. The running remainder is joined
  // with the next dividend bit; if that reaches the divisor, it is
  // subtracted and the quotient bit is one.
  function automatic divu_pkg::stage_t div_step(input divu_pkg::stage_t s_in);
    logic [divu_pkg::DIVISOR_W:0] part;
    logic [divu_pkg::DIVISOR_W:0] diff;
    logic                         ge;
    divu_pkg::stage_t             s_out;
    part          = {s_in.rem, s_in.work[divu_pkg::DIVIDEND_W-1]};
    diff          = part - {1'b0, s_in.divisor};
    ge            = (part >= {1'b0, s_in.divisor});
    s_out.divisor = s_in.divisor;
    s_out.rem     = ge ? diff[divu_pkg::DIVISOR_W-1:0] : part[divu_pkg::DIVISOR_W-1:0];
    s_out.work    = {s_in.work[divu_pkg::DIVIDEND_W-2:0], ge};
    return s_out;
  endfunction

  logic              accept;
  logic [STAGES-1:0] stg_vld_r;
  divu_pkg::stage_t  stg_r [STAGES];
  divu_pkg::stage_t  stg_nxt [STAGES];

  logic               out_valid_r;
  divu_pkg::out_word_t out_data_r;
  divu_pkg::out_word_t out_data_nxt;

  // The pipeline always advances, so the block is never busy.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // The valid bits travel with the working words, one stage per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= '0;
    end else begin
      stg_vld_r <= {stg_vld_r[STAGES-2:0], accept};
    end
  end

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    divu_pkg::stage_t stg_in;

    if (s == 0) begin : g_first
      // A fresh division starts with a zero remainder.
      always_comb begin
        stg_in.rem     = '0;
        stg_in.work    = in_data.dividend;
        stg_in.divisor = in_data.divisor;
      end
    end else begin : g_rest
      assign stg_in = stg_r[s-1];
    end

    always_comb begin
      stg_nxt[s] = stg_in;
      for (int b = 0; b < STAGE_BITS; b++) begin
        stg_nxt[s] = div_step(stg_nxt[s]);
      end
    end

    // The payload needs no reset; its valid bit says when it means anything.
    always_ff @(posedge clk) begin
      stg_r[s] <= stg_nxt[s];
    end
  end

  // After the last stage every dividend bit has been shifted out, so the
  // working word holds the whole quotient. A zero divisor would have made
  // every quotient bit one; that case is forced to zero and flagged.
  always_comb begin
    out_data_nxt.divide_by_zero = (stg_r[STAGES-1].divisor == '0);
    out_data_nxt.quotient       = out_data_nxt.divide_by_zero ? '0 : stg_r[STAGES-1].work;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= stg_vld_r[STAGES-1];
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Every accepted word comes out after the fixed latency.
  `DIVU_ASSERT_DELAY(a_latency, accept, LAT, out_valid)

  // A zero divisor at the input is reported on the matching result.
  `DIVU_ASSERT_DELAY(a_zero_flag, accept && (in_data.divisor == '0), LAT, out_data.divide_by_zero)

  // No result appears without a word taken the fixed latency earlier.
  `DIVU_ASSERT_IMPL(a_no_phantom, out_valid, $past(accept, LAT))

  // The carried remainder always stays below a nonzero divisor.
  for (genvar s = 0; s < STAGES; s++) begin : g_chk
    logic chk_en;
    assign chk_en = stg_vld_r[s] && (stg_r[s].divisor != '0);
    `DIVU_ASSERT_IMPL(a_rem_bound, chk_en, stg_r[s].rem < stg_r[s].divisor)
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

// Testbench for the pipelined 64-by-16 unsigned divider.
//
// Operand words are sent at the falling clock edge and taken at the rising
// edge where start is high and busy is low. Each accepted word goes to a small
// scoreboard. The scoreboard works out the expected quotient on its own, by
// long division over four 16-bit digits, and queues it. Every result word that
// comes out with out_valid is checked, field by field, against the oldest
// queued expectation. The divider returns its results in issue order, so the
// order of the results alone ties them to their operands.

module tb_top;

  // Latency in rising edges, from taking an operand to taking its result.
  localparam int PIPE_LATENCY  = 17;
  // Cycles with neither an accepted operand word nor a result before the run
  // is given up. The longest correct quiet spell is a random gap of the sender
  // plus the pipeline latency, far below this.
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_WORDS  = 1280;
  localparam int IDLE_PERCENT  = 26;
  localparam int MAX_PRINTED   = 100;

  // Holds the expected quotients in issue order and checks the results.
  class quotient_scoreboard;
    divu_pkg::out_word_t expected_q[$];
    int                  mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Prints one line per mismatch, up to a cap, and counts every one.
    task report_mismatch(input string msg);
      if (mismatches < MAX_PRINTED) begin
        $display("MISMATCH at %0t ns: %s", $time, msg);
      end
      mismatches++;
    endtask

    // Long division from the most significant 16-bit digit downward. The
    // running remainder is always below the divisor, so each digit of the
    // quotient fits in 16 bits.
    function divu_pkg::out_word_t predict_quotient(input divu_pkg::in_word_t w);
      divu_pkg::out_word_t res;
      logic [15:0]         rem;
      logic [31:0]         part;
      res.quotient       = '0;
      res.divide_by_zero = 1'b0;
      rem                = '0;
      if (w.divisor == '0) begin
        res.divide_by_zero = 1'b1;
      end else begin
        for (int k = 3; k >= 0; k--) begin
          part         = {rem, w.dividend[k*16 +: 16]};
          res.quotient = {res.quotient[47:0], 16'(part / {16'd0, w.divisor})};
          rem          = 16'(part % {16'd0, w.divisor});
        end
      end
      return res;
    endfunction

    function void note_word(input divu_pkg::in_word_t w);
      expected_q.push_back(predict_quotient(w));
    endfunction

    task check_word(input divu_pkg::out_word_t got);
      divu_pkg::out_word_t exp_w;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result with no word waiting: quotient %h dbz %b",
                                  got.quotient, got.divide_by_zero));
      end else begin
        exp_w = expected_q.pop_front();
        if (got.quotient !== exp_w.quotient) begin
          report_mismatch($sformatf("quotient %h, expected %h",
                                    got.quotient, exp_w.quotient));
        end
        if (got.divide_by_zero !== exp_w.divide_by_zero) begin
          report_mismatch($sformatf("divide_by_zero %b, expected %b",
                                    got.divide_by_zero, exp_w.divide_by_zero));
        end
      end
    endtask
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  divu_pkg::in_word_t  in_data;
  logic                out_valid;
  divu_pkg::out_word_t out_data;

  quotient_scoreboard sb;
  int                 quiet_cycles;
  // Cleared for words 400 to 699 of the random part so that those words are
  // offered back to back.
  bit                 gaps_enabled;

  divide_u64_by_u16_unit uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Offers one operand word, after a random number of idle cycles, and keeps
  // it on the inputs until the divider takes it. Every falling edge carries at
  // most one assignment to start, so a run of words keeps start high.
  task automatic send_word(input divu_pkg::in_word_t w);
    while (gaps_enabled && $urandom_range(99) < IDLE_PERCENT) begin
      @(negedge clk);
      start <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    start   <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_word(w);
  endtask

  // Random operands. Small divisors, powers of two and divisors near the top
  // of the range stress the digit carries; small or shifted dividends give
  // divisors larger than the dividend and leading zero digits.
  function automatic divu_pkg::in_word_t random_word();
    divu_pkg::in_word_t w;
    int                 pick;
    w.dividend = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 8) begin
      w.divisor = '0;
    end else if (pick < 28) begin
      w.divisor = 16'($urandom_range(255, 1));
    end else if (pick < 40) begin
      w.divisor = 16'd1 << $urandom_range(15);
    end else if (pick < 48) begin
      w.divisor = 16'hFFFF - 16'($urandom_range(15));
    end else begin
      w.divisor = 16'($urandom);
    end
    pick = $urandom_range(99);
    if (pick < 10) begin
      w.dividend = 64'($urandom_range(65535));
    end else if (pick < 22) begin
      w.dividend = w.dividend >> $urandom_range(63);
    end
    return w;
  endfunction

  // Result checking and the watchdog. Outputs are sampled at the rising edge,
  // before the divider's own updates for that edge take effect.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        sb.check_word(out_data);
      end
      if ((start && !busy) || out_valid) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TIMEOUT: no progress for %0d cycles", STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    sb           = new();
    quiet_cycles = 0;
    gaps_enabled = 1'b1;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_data      = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words: the extremes of both fields, a zero divisor, a divisor
    // larger than the dividend, equal operands and digit patterns that make
    // the remainder carry across every digit boundary.
    send_word(divu_pkg::in_word_t'{64'h0, 16'h0001});
    send_word(divu_pkg::in_word_t'{64'h0, 16'h0000});
    send_word(divu_pkg::in_word_t'{64'hFFFF_FFFF_FFFF_FFFF, 16'h0000});
    send_word(divu_pkg::in_word_t'{64'h1, 16'h0000});
    send_word(divu_pkg::in_word_t'{64'hFFFF_FFFF_FFFF_FFFF, 16'h0001});
    send_word(divu_pkg::in_word_t'{64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF});
    send_word(divu_pkg::in_word_t'{64'hFFFF_FFFF_FFFF_FFFF, 16'h0002});
    send_word(divu_pkg::in_word_t'{64'hFFFF_FFFF_FFFF_FFFE, 16'hFFFF});
    send_word(divu_pkg::in_word_t'{64'h5, 16'h0064});
    send_word(divu_pkg::in_word_t'{64'hFFFE, 16'hFFFF});
    send_word(divu_pkg::in_word_t'{64'h1, 16'hFFFF});
    send_word(divu_pkg::in_word_t'{64'hFFFF, 16'hFFFF});
    send_word(divu_pkg::in_word_t'{64'h8000_0000_0000_0000, 16'h8000});
    send_word(divu_pkg::in_word_t'{64'h0001_0000_0000_0000, 16'h0003});
    send_word(divu_pkg::in_word_t'{64'h1234_5678_9ABC_DEF0, 16'h1234});
    send_word(divu_pkg::in_word_t'{64'h00FF_00FF_00FF_00FF, 16'h0100});
    send_word(divu_pkg::in_word_t'{64'hAAAA_AAAA_AAAA_AAAA, 16'h5555});
    send_word(divu_pkg::in_word_t'{64'h5555_5555_5555_5555, 16'hAAAA});
    send_word(divu_pkg::in_word_t'{64'hFFFF_0000_FFFF_0000, 16'hFFFE});
    send_word(divu_pkg::in_word_t'{64'h0000_FFFF_FFFF_FFFF, 16'h0007});
    send_word(divu_pkg::in_word_t'{64'h7FFF_FFFF_FFFF_FFFF, 16'h8001});

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      gaps_enabled = !(i >= 400 && i < 700);
      send_word(random_word());
    end
    @(negedge clk);
    start <= 1'b0;

    // Drain the pipeline, then give stray results time to show up.
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 8) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[divide_u64_by_u16_unit.f]
+incdir+design
design/divu_pkg.sv
design/divide_u64_by_u16_unit.sv
tb/tb_top.sv
